[design/iqs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package iqs_pkg;
  localparam int MaxItems  = 64;
  localparam int DataWidth = 32;
  localparam int IdxW      = $clog2(MaxItems);
  localparam int CntW      = $clog2(MaxItems + 1);
  localparam int RangeW    = 2 * IdxW;

  typedef logic [IdxW-1:0]      idx_t;
  typedef logic [CntW-1:0]      cnt_t;
  typedef logic [DataWidth-1:0] data_t;

  // controller to datapath commands
  typedef struct packed {
    logic store_we;      // write sample at count
    logic cnt_clr;       // clear count and overflow
    logic mark_ovf;      // note a dropped item
    logic mem_re;        // issue element read
    idx_t mem_raddr;
    logic mem_we;        // element write
    idx_t mem_waddr;
    logic wsel_b;        // write data: 0 reg a, 1 reg b
    logic wsel_pv;       // write data: pivot register
    logic lat_a;         // latch read data into reg a
    logic lat_b;         // latch read data into reg b
    logic lat_pv;        // latch read data as pivot
    logic lat_out;       // latch read data as output value
    logic stk_we;
    idx_t stk_waddr;
    logic [RangeW-1:0] stk_wdata;
    logic stk_re;
    idx_t stk_raddr;
  } iqs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    cnt_t count;
    logic ovf;
    logic less;                    // reg b < pivot
    logic [RangeW-1:0] stk_rdata;
  } iqs_sts_t;

  function automatic logic signed_less(data_t a, data_t b);
    return $signed(a) < $signed(b);
  endfunction
endpackage
`default_nettype wire

[design/iqs_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface iqs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_value;
  logic        is_last;
  modport source (output valid, sample_value, is_last, input ready);
  modport sink   (input valid, sample_value, is_last, output ready);
endinterface

interface iqs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sorted_value;
  logic        final_item;
  logic        overflow_flag;
  modport source (output valid, sorted_value, final_item, overflow_flag, input ready);
  modport sink   (input valid, sorted_value, final_item, overflow_flag, output ready);
endinterface
`default_nettype wire

[design/iqs_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module iqs_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[design/iqs_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module iqs_datapath import iqs_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire iqs_cmd_t  cmd_i,
  input  wire logic [31:0] sample_i,
  output iqs_sts_t       sts_o,
  output data_t          out_value_o
);
  cnt_t  cnt_q;
  logic  ovf_q;
  data_t a_q, b_q, pv_q, out_q, rd;
  data_t wdata;
  idx_t  waddr;

  // count and overflow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      if (cmd_i.store_we) cnt_q <= cnt_q + cnt_t'(1);
      if (cmd_i.mark_ovf) ovf_q <= 1'b1;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_a)   a_q   <= rd;
    if (cmd_i.lat_b)   b_q   <= rd;
    if (cmd_i.lat_pv)  pv_q  <= rd;
    if (cmd_i.lat_out) out_q <= rd;
  end

  // element write select
  always_comb begin
    if (cmd_i.store_we) begin
      wdata = sample_i[DataWidth-1:0];
      waddr = cnt_q[IdxW-1:0];
    end else begin
      if (cmd_i.wsel_pv) wdata = pv_q;
      else wdata = cmd_i.wsel_b ? b_q : a_q;
      waddr = cmd_i.mem_waddr;
    end
  end

  iqs_ram #(.Width(DataWidth), .Depth(MaxItems)) u_elem (
    .clk_i, .we_i(cmd_i.store_we | cmd_i.mem_we), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(cmd_i.mem_re), .raddr_i(cmd_i.mem_raddr), .rdata_o(rd)
  );

  iqs_ram #(.Width(RangeW), .Depth(MaxItems)) u_stack (
    .clk_i, .we_i(cmd_i.stk_we), .waddr_i(cmd_i.stk_waddr), .wdata_i(cmd_i.stk_wdata),
    .re_i(cmd_i.stk_re), .raddr_i(cmd_i.stk_raddr), .rdata_o(sts_o.stk_rdata)
  );

  assign sts_o.count = cnt_q;
  assign sts_o.ovf   = ovf_q;
  assign sts_o.less  = signed_less(b_q, pv_q);
  assign out_value_o = out_q;
endmodule
`default_nettype wire

[design/iqs_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module iqs_ctrl import iqs_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_last_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output logic          out_final_o,
  input  wire iqs_sts_t sts_i,
  output iqs_cmd_t      cmd_o
);
  typedef enum logic [3:0] {
    S_LOAD, S_POP, S_POPW, S_PIVW, S_RDI, S_RDW, S_CMP, S_SWS,
    S_FINR, S_FINW, S_FINS, S_PUSH, S_EMR, S_EMW, S_EMV
  } state_e;

  state_e state_q, state_d;
  idx_t lo_q, lo_d, hi_q, hi_d, i_q, i_d, st_q, st_d, k_q, k_d;
  cnt_t top_q, top_d, n_q, n_d;
  logic ovalid_q, ovalid_d, ofinal_q, ofinal_d;
  logic push2_q, push2_d;   // second push pending
  logic [RangeW-1:0] r2_q, r2_d;
  logic acc;
  iqs_cmd_t c;
  logic [IdxW:0] p1, lo1;

  assign acc        = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_LOAD);
  assign p1  = {1'b0, st_q} + (IdxW+1)'(1);
  assign lo1 = {1'b0, lo_q} + (IdxW+1)'(1);

  // next state and commands
  always_comb begin
    state_d = state_q; lo_d = lo_q; hi_d = hi_q; i_d = i_q; st_d = st_q; k_d = k_q;
    top_d = top_q; n_d = n_q; ovalid_d = ovalid_q; ofinal_d = ofinal_q;
    push2_d = push2_q; r2_d = r2_q;
    c = '0;
    unique case (state_q)
      S_LOAD: begin
        if (acc) begin
          if (sts_i.count != cnt_t'(MaxItems)) c.store_we = 1'b1;
          else c.mark_ovf = 1'b1;
          if (in_last_i) begin
            n_d = (sts_i.count != cnt_t'(MaxItems)) ? sts_i.count + cnt_t'(1) : sts_i.count;
            k_d = '0;
            if (n_d >= cnt_t'(2)) begin
              // whole set goes on the stack, pivot read once the last sample is in
              c.stk_we = 1'b1; c.stk_waddr = '0;
              c.stk_wdata = {idx_t'(0), idx_t'(n_d - cnt_t'(1))};
              top_d = cnt_t'(1);
              state_d = S_POP;
            end else state_d = S_EMR;
          end
        end
      end
      S_POP: begin
        if (top_q == '0) begin
          k_d = '0; state_d = S_EMR;
        end else begin
          top_d = top_q - cnt_t'(1);
          c.stk_re = 1'b1; c.stk_raddr = idx_t'(top_d);
          state_d = S_POPW;
        end
      end
      S_POPW: begin
        lo_d = sts_i.stk_rdata[RangeW-1:IdxW]; hi_d = sts_i.stk_rdata[IdxW-1:0];
        c.mem_re = 1'b1; c.mem_raddr = hi_d;
        state_d = S_PIVW;
      end
      S_PIVW: begin
        c.lat_pv = 1'b1; i_d = lo_q; st_d = lo_q;
        state_d = S_RDI;
      end
      S_RDI: begin
        if (i_q == hi_q) begin
          c.mem_re = 1'b1; c.mem_raddr = st_q;
          state_d = S_FINR;
        end else begin
          c.mem_re = 1'b1; c.mem_raddr = i_q;
          state_d = S_RDW;
        end
      end
      S_RDW: begin
        c.lat_b = 1'b1;
        c.mem_re = 1'b1; c.mem_raddr = st_q;
        state_d = S_CMP;
      end
      S_CMP: begin
        c.lat_a = 1'b1;
        if (sts_i.less) state_d = S_SWS;
        else begin
          i_d = i_q + idx_t'(1); state_d = S_RDI;
        end
      end
      S_SWS: begin
        // swap: store slot gets b, i gets a (a stays valid after write)
        c.mem_we = 1'b1; c.mem_waddr = st_q; c.wsel_b = 1'b1;
        state_d = S_FINS;
      end
      S_FINS: begin
        c.mem_we = 1'b1; c.mem_waddr = i_q; c.wsel_b = 1'b0;
        st_d = st_q + idx_t'(1); i_d = i_q + idx_t'(1);
        state_d = S_RDI;
      end
      S_FINR: begin
        c.lat_a = 1'b1; state_d = S_FINW;
      end
      S_FINW: begin
        // store slot gets pivot, hi gets old store value
        c.mem_we = 1'b1; c.mem_waddr = hi_q; c.wsel_b = 1'b0;
        state_d = S_PUSH;
        push2_d = 1'b0;
        r2_d = {st_q + idx_t'(1), hi_q};
      end
      S_PUSH: begin
        if (!push2_q) begin
          // write pivot copy in place, then first push
          c.mem_we = 1'b1; c.mem_waddr = st_q; c.wsel_pv = 1'b1;
          push2_d = 1'b1;
          if ({1'b0, st_q} > lo1 && top_q < cnt_t'(MaxItems)) begin
            c.stk_we = 1'b1; c.stk_waddr = idx_t'(top_q);
            c.stk_wdata = {lo_q, st_q - idx_t'(1)};
            top_d = top_q + cnt_t'(1);
          end
        end else begin
          if (p1 < {1'b0, hi_q} && top_q < cnt_t'(MaxItems)) begin
            c.stk_we = 1'b1; c.stk_waddr = idx_t'(top_q); c.stk_wdata = r2_q;
            top_d = top_q + cnt_t'(1);
          end
          state_d = S_POP;
        end
      end
      S_EMR: begin
        c.mem_re = 1'b1; c.mem_raddr = k_q;
        state_d = S_EMW;
      end
      S_EMW: begin
        c.lat_out = 1'b1;
        ovalid_d = 1'b1;
        ofinal_d = ({1'b0, k_q} + (IdxW+1)'(1)) == (IdxW+1)'(n_q);
        state_d = S_EMV;
      end
      S_EMV: begin
        if (out_ready_i) begin
          ovalid_d = 1'b0;
          if (ofinal_q) begin
            c.cnt_clr = 1'b1; state_d = S_LOAD;
          end else begin
            k_d = k_q + idx_t'(1); state_d = S_EMR;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD; top_q <= '0; n_q <= '0; ovalid_q <= 1'b0; ofinal_q <= 1'b0;
      lo_q <= '0; hi_q <= '0; i_q <= '0; st_q <= '0; k_q <= '0;
      push2_q <= 1'b0; r2_q <= '0;
    end else begin
      state_q <= state_d; top_q <= top_d; n_q <= n_d; ovalid_q <= ovalid_d;
      ofinal_q <= ofinal_d; lo_q <= lo_d; hi_q <= hi_d; i_q <= i_d; st_q <= st_d;
      k_q <= k_d; push2_q <= push2_d; r2_q <= r2_d;
    end
  end

  // the pivot write in S_PUSH takes the pivot register
  assign cmd_o       = c;
  assign out_valid_o = ovalid_q;
  assign out_final_o = ofinal_q;
endmodule
`default_nettype wire

[design/iterative_quicksort_engine.sv]
// load: one item per cycle while in the load state; sorting then runs
// iterative Lomuto passes over index ranges kept on an explicit stack
// runs: one run at a time, no new sample until the final result is taken;
// results are read one at a time through the single element RAM read port
// reset: rst_ni asynchronous active low clears count, overflow and controller
`timescale 1ns / 1ps
`default_nettype none
module iterative_quicksort_engine import iqs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  iqs_in_if.sink    in_if,
  iqs_out_if.source out_if
);
  iqs_cmd_t cmd;
  iqs_sts_t sts;
  data_t    val;

  iqs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_last_i(in_if.is_last), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .out_final_o(out_if.final_item), .sts_i(sts), .cmd_o(cmd)
  );

  iqs_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sample_i(in_if.sample_value),
    .sts_o(sts), .out_value_o(val)
  );

  assign out_if.sorted_value  = 32'($signed(val));
  assign out_if.overflow_flag = sts.ovf;
endmodule
`default_nettype wire

[design/iqs_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module iqs_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] out_value,
  input wire logic out_final
);
  // no loading while results are shown
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("ready while emitting");
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_final))
    else $error("result changed under stall");
  // after the final result is taken the block returns to loading
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && out_final |=> in_ready) else $error("no return to load");
endmodule

bind iterative_quicksort_engine iqs_checker u_chk (
  .clk_i, .rst_ni, .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_value(out_if.sorted_value), .out_final(out_if.final_item)
);
`default_nettype wire
